>>> src/assert_macros.svh
// Assertion macros used by the top level of the ordered list block.
// Clocked on clk_i and disabled during rst_ni low; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define OLDBV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define OLDBV_ASSERT_IMPL(lbl, ante, cons, msg) \
  `OLDBV_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define OLDBV_ASSERT(lbl, prop, msg)
`define OLDBV_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> src/oldbv_pkg.sv
// Types and constants of the ordered list block.
// No dependencies; used by the interfaces, the cell, the result queue and the top.
package oldbv_pkg;

  localparam int unsigned ValW      = 32;
  localparam int unsigned CountOutW = 7;

  typedef logic signed [ValW-1:0]   value_t;
  typedef logic [CountOutW-1:0]     count_out_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic scan_start;
    logic scan_run;
    logic del;
  } cell_ctrl_t;

  typedef struct packed {
    logic       removed;
    logic       dropped;
    count_out_t entry_count;
  } result_t;

endpackage

>>> src/oldbv_if.sv
// Valid/ready channel interfaces: input items, results and the mode register write.
// Depends on oldbv_pkg.
interface oldbv_in_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  oldbv_pkg::value_t    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface oldbv_out_if;
  logic                  valid;
  logic                  ready;
  logic                  removed;
  logic                  dropped;
  oldbv_pkg::count_out_t entry_count;

  modport source (output valid, output removed, output dropped, output entry_count,
                  input ready);
  modport sink   (input valid, input removed, input dropped, input entry_count,
                  output ready);
endinterface

interface oldbv_cfg_if;
  logic valid;
  logic ready;
  logic insert_at_back;

  modport source (output valid, output insert_at_back, input ready);
  modport sink   (input valid, input insert_at_back, output ready);
endinterface

>>> src/ordered_list_delete_by_value.sv
// Top level of the ordered list with insert and delete-by-value: control FSM and cell chain.
// Depends on oldbv_pkg, oldbv_if, oldbv_cell, oldbv_resq and assert_macros.svh.
//
//  channel | modport     | payload                            | transaction
//  in_i    | sink        | operation, value                   | one list operation
//  out_o   | source      | removed, dropped, entry_count      | one result per operation
//  cfg_i   | sink        | insert_at_back                     | mode register write
//
// Insert: completes in the accepting cycle.
// Remove: the search token walks the cell chain one position per cycle, all later cells
//   shift at once.
// Input is taken only in idle and while the result queue has room; results wait in a
//   two-entry queue. Reset clears the count, occupied flags and mode, no clearing pass.
`include "assert_macros.svh"

module ordered_list_delete_by_value #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oldbv_in_if.sink    in_i,
  oldbv_out_if.source out_o,
  oldbv_cfg_if.sink   cfg_i
);
  import oldbv_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  value_t          key_q;
  logic            mode_q;

  cell_ctrl_t      ctrl;
  value_t          bus_val;
  value_t          val_vec [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] tok_vec;
  logic [CAPACITY-1:0] hit_vec;

  logic    in_acc;
  logic    is_remove;
  logic    full;
  logic    hit_any;
  logic    miss;
  logic    q_full;
  logic    push;
  result_t push_data;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE) & ~q_full;
  assign in_acc      = in_i.valid & in_i.ready;
  assign is_remove   = (in_i.operation == OP_REMOVE);
  assign full        = (count_q == CntW'(CAPACITY));
  assign hit_any     = |hit_vec;
  assign miss        = (pos_q == count_q);
  assign bus_val     = (state_q == ST_SCAN) ? key_q : in_i.value;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_remove) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_any || miss) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    count_d   = count_q;
    pos_d     = pos_q;
    push      = 1'b0;
    push_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_remove) begin
            ctrl.scan_start = 1'b1;
            ctrl.scan_run   = 1'b1;
            pos_d           = '0;
          end else begin
            if (!full) begin
              ctrl.ins_front = ~mode_q;
              ctrl.ins_back  = mode_q;
              count_d        = count_q + 1'b1;
            end
            push                  = 1'b1;
            push_data.dropped     = full;
            push_data.entry_count = CountOutW'(count_d);
          end
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          ctrl.del               = 1'b1;
          count_d                = count_q - 1'b1;
          push                   = 1'b1;
          push_data.removed      = 1'b1;
          push_data.entry_count  = CountOutW'(count_d);
        end else if (miss) begin
          push                   = 1'b1;
          push_data.entry_count  = CountOutW'(count_q);
        end else begin
          ctrl.scan_run = 1'b1;
          pos_d         = pos_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.insert_at_back;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_remove) begin
      key_q <= in_i.value;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t prev_val;
    value_t next_val;
    logic   prev_occ;
    logic   prev_tok;
    logic   next_occ;

    if (g == 0) begin : g_head
      assign prev_val = bus_val;
      assign prev_occ = 1'b1;
      assign prev_tok = ctrl.scan_start;
    end else begin : g_mid
      assign prev_val = val_vec[g-1];
      assign prev_occ = occ_vec[g-1];
      assign prev_tok = tok_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_val = val_vec[g];
      assign next_occ = 1'b0;
    end else begin : g_body
      assign next_val = val_vec[g+1];
      assign next_occ = occ_vec[g+1];
    end

    oldbv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .bus_val_i  (bus_val),
      .prev_val_i (prev_val),
      .prev_occ_i (prev_occ),
      .prev_tok_i (prev_tok),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (val_vec[g]),
      .occ_o      (occ_vec[g]),
      .tok_o      (tok_vec[g]),
      .hit_o      (hit_vec[g])
    );
  end

  oldbv_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_o       (out_o)
  );

  `OLDBV_ASSERT(a_count_le_cap, count_q <= CntW'(CAPACITY), "count above capacity")
  `OLDBV_ASSERT(a_tok_onehot0, $onehot0(tok_vec), "more than one search token")
  `OLDBV_ASSERT(a_occ_count, $countones(occ_vec) == int'(count_q), "occupied flags vs count")
  `OLDBV_ASSERT_IMPL(a_scan_pos, state_q == ST_SCAN, pos_q <= count_q, "token past list end")
  `OLDBV_ASSERT_IMPL(a_tok_start, in_acc && is_remove, ##1 tok_vec[0], "search did not start")

endmodule

>>> src/oldbv_cell.sv
// One list position: value, occupied flag, search token and passed flag.
// Depends on oldbv_pkg; instantiated in a chain by ordered_list_delete_by_value.
module oldbv_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  oldbv_pkg::cell_ctrl_t ctrl_i,
  input  oldbv_pkg::value_t     bus_val_i,
  input  oldbv_pkg::value_t     prev_val_i,
  input  logic                  prev_occ_i,
  input  logic                  prev_tok_i,
  input  oldbv_pkg::value_t     next_val_i,
  input  logic                  next_occ_i,
  output oldbv_pkg::value_t     val_o,
  output logic                  occ_o,
  output logic                  tok_o,
  output logic                  hit_o
);
  import oldbv_pkg::*;

  value_t val_q, val_d;
  logic   occ_q, occ_d;
  logic   tok_q, tok_d;
  logic   pass_q, pass_d;

  always_comb begin
    val_d  = val_q;
    occ_d  = occ_q;
    pass_d = pass_q;
    tok_d  = ctrl_i.scan_run & prev_tok_i;
    if (ctrl_i.ins_front) begin
      val_d = prev_val_i;
      occ_d = prev_occ_i;
    end else if (ctrl_i.ins_back) begin
      if (!occ_q && prev_occ_i) begin
        val_d = bus_val_i;
        occ_d = 1'b1;
      end
    end
    if (ctrl_i.scan_start) begin
      pass_d = 1'b0;
    end else if (ctrl_i.del) begin
      // close the gap: every position the token has not passed moves up
      if (!pass_q) begin
        val_d = next_val_i;
        occ_d = next_occ_i;
      end
    end else if (tok_q) begin
      pass_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      tok_q  <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      tok_q  <= tok_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;
  assign tok_o = tok_q;
  assign hit_o = tok_q & occ_q & (val_q == bus_val_i);

endmodule

>>> src/oldbv_resq.sv
// Two-entry result queue: output register plus skid entry.
// Depends on oldbv_pkg and oldbv_out_if.
module oldbv_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  oldbv_pkg::result_t push_data_i,
  output logic               full_o,
  oldbv_out_if.source        out_o
);
  import oldbv_pkg::*;

  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    head_v_q, head_v_d;
  logic    skid_v_q, skid_v_d;
  logic    pop;

  assign pop = head_v_q & out_o.ready;

  always_comb begin
    head_d   = head_q;
    head_v_d = head_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        head_v_d = 1'b1;
        skid_v_d = push_i;
        skid_d   = push_data_i;
      end else begin
        head_v_d = push_i;
        head_d   = push_data_i;
      end
    end else if (!head_v_q) begin
      head_v_d = push_i;
      head_d   = push_data_i;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o            = skid_v_q;
  assign out_o.valid       = head_v_q;
  assign out_o.removed     = head_q.removed;
  assign out_o.dropped     = head_q.dropped;
  assign out_o.entry_count = head_q.entry_count;

endmodule
